// ----- rtl/hlt_pkg.sv -----
// Shared types and constants of the heartbeat liveness table.
// Used by hlt_table, hlt_due and heartbeat_liveness_table; depends on nothing.
package hlt_pkg;

    localparam int SLOTS   = 16;
    localparam int PTR_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SENT_W  = $clog2(SLOTS + 1);
    localparam int MASK_W  = 16;
    localparam int PAD_W   = (SLOTS > MASK_W) ? SLOTS : MASK_W;
    localparam int ADDR_W  = 32;
    localparam int TIME_W  = 64;
    localparam int RETRY_W = 3;
    localparam int IVL_W   = 16;
    localparam int LEN_W   = 6;

    localparam logic [IVL_W-1:0]   RST_INTERVAL  = 16'd5000;
    localparam logic [RETRY_W-1:0] RST_RETRIES   = 3'd5;
    localparam logic [LEN_W-1:0]   RST_REPLY_LEN = 6'd13;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_REPLY = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        KIND_PROBE   = 3'd0,
        KIND_DONE    = 3'd1,
        KIND_MATCH   = 3'd2,
        KIND_UNKNOWN = 3'd3,
        KIND_ACK     = 3'd4
    } t_kind;

    localparam logic [1:0] CFG_INTERVAL  = 2'd0;
    localparam logic [1:0] CFG_RETRIES   = 2'd1;
    localparam logic [1:0] CFG_REPLY_LEN = 2'd2;

    typedef logic [PAD_W-1:0] t_pad_mask;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [TIME_W-1:0]  ptime;
        logic [RETRY_W-1:0] retry;
    } t_entry;

    typedef struct packed {
        logic               we_addr;
        logic               we_time;
        logic               we_retry;
        logic               we_off;
        logic [PTR_W-1:0]   idx;
        logic [ADDR_W-1:0]  addr;
        logic [TIME_W-1:0]  ptime;
        logic [RETRY_W-1:0] retry;
        logic               off;
    } t_tbl_wr;

    typedef struct packed {
        logic probe;
        logic offline;
        logic match;
    } t_slot_dec;

endpackage

// ----- rtl/hlt_table.sv -----
// Peer table: address, last probe time, retry count and offline flag per slot.
// One read port at the walk pointer, one write port. Depends on hlt_pkg.
module hlt_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [hlt_pkg::PTR_W-1:0]     i_rd_idx,
    output hlt_pkg::t_entry               o_rd,
    input  hlt_pkg::t_tbl_wr              i_wr,
    output logic [hlt_pkg::SLOTS-1:0]     o_offline_nxt
);

    logic [hlt_pkg::ADDR_W-1:0]  r_addr  [hlt_pkg::SLOTS];
    logic [hlt_pkg::TIME_W-1:0]  r_time  [hlt_pkg::SLOTS];
    logic [hlt_pkg::RETRY_W-1:0] r_retry [hlt_pkg::SLOTS];
    logic [hlt_pkg::SLOTS-1:0]   r_off;
    logic [hlt_pkg::SLOTS-1:0]   n_off;

    assign o_rd.addr  = r_addr[i_rd_idx];
    assign o_rd.ptime = r_time[i_rd_idx];
    assign o_rd.retry = r_retry[i_rd_idx];

    always_comb begin
        n_off = r_off;
        if (i_wr.we_off) begin
            n_off[i_wr.idx] = i_wr.off;
        end
    end

    assign o_offline_nxt = n_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < hlt_pkg::SLOTS; k++) begin
                r_addr[k]  <= '0;
                r_time[k]  <= '0;
                r_retry[k] <= '0;
            end
            r_off <= '0;
        end else begin
            if (i_wr.we_addr) begin
                r_addr[i_wr.idx] <= i_wr.addr;
            end
            if (i_wr.we_time) begin
                r_time[i_wr.idx] <= i_wr.ptime;
            end
            if (i_wr.we_retry) begin
                r_retry[i_wr.idx] <= i_wr.retry;
            end
            r_off <= n_off;
        end
    end

endmodule

// ----- rtl/hlt_due.sv -----
// Shared slot evaluator: due test (64-bit subtract and compare), retry limit
// and reply address match for the slot under the walk pointer. Depends on hlt_pkg.
module hlt_due (
    input  hlt_pkg::t_entry                i_ent,
    input  logic [hlt_pkg::TIME_W-1:0]     i_now,
    input  logic                           i_force,
    input  logic [hlt_pkg::ADDR_W-1:0]     i_peer,
    input  logic [hlt_pkg::IVL_W-1:0]      i_interval,
    input  logic [hlt_pkg::RETRY_W-1:0]    i_max_retries,
    output hlt_pkg::t_slot_dec             o_dec
);

    logic                        used;
    logic [hlt_pkg::TIME_W:0]    diff;
    logic                        backwards;
    logic                        elapsed;
    logic                        due;

    assign used      = (i_ent.addr != '0);
    // Borrow out of now - last probe flags a clock that ran backwards.
    assign diff      = {1'b0, i_now} - {1'b0, i_ent.ptime};
    assign backwards = diff[hlt_pkg::TIME_W];
    assign elapsed   = (diff[hlt_pkg::TIME_W-1:hlt_pkg::IVL_W] != '0)
                    || (diff[hlt_pkg::IVL_W-1:0] >= i_interval);
    assign due       = used && (i_ent.ptime != '0) && !backwards && elapsed;

    always_comb begin
        o_dec = '0;
        if (i_force) begin
            o_dec.probe = used;
        end else if (due) begin
            if (i_ent.retry >= i_max_retries) begin
                o_dec.offline = 1'b1;
            end else begin
                o_dec.probe = 1'b1;
            end
        end
        o_dec.match = used && (i_ent.addr == i_peer);
    end

endmodule

// ----- rtl/heartbeat_liveness_table.sv -----
// Heartbeat liveness table, top level: command sequencer, output register
// and configuration registers. Instantiates hlt_table and hlt_due; uses hlt_pkg.

// A load passes from its transfer to the load state, which writes the slot and
// presents the acknowledge when the output register can take it. A tick walks
// every slot through the shared due evaluator, one per cycle while the output
// side does not stall (a probe waits in place until the output register can
// take it), then presents the tick-done result from the done state. A reply
// with the wrong length answers from the reply state without a walk; otherwise
// it walks slots until the first used slot holding the source address, and an
// unknown reply ends in the done state. The input side stalls for the whole
// walk. Results leave through one output register, so the block can start on the
// next item while the final result of the previous one still waits to be taken.
// The offline mask on every result shows the flags as they stand after the step
// that produced it. Configuration writes are always ready and take effect at
// once; write them only while the block is idle. Command 3 is accepted and dropped.
module heartbeat_liveness_table (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_cmd,
    input  logic [3:0]                        i_entry_index,
    input  logic [hlt_pkg::ADDR_W-1:0]        i_peer_address,
    input  logic [hlt_pkg::TIME_W-1:0]        i_now_ms,
    input  logic                              i_force_req,
    input  logic [hlt_pkg::LEN_W-1:0]         i_packet_length,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [2:0]                        o_kind,
    output logic [3:0]                        o_slot,
    output logic [hlt_pkg::ADDR_W-1:0]        o_target_address,
    output logic [hlt_pkg::TIME_W-1:0]        o_probe_stamp,
    output logic [4:0]                        o_probes_sent,
    output logic [hlt_pkg::MASK_W-1:0]        o_offline_mask,
    output logic                              o_last,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [1:0]                        i_cfg_index,
    input  logic [hlt_pkg::IVL_W-1:0]         i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_TICK,
        S_REPLY,
        S_DONE
    } t_state;

    t_state                          r_state, n_state;
    logic [hlt_pkg::PTR_W-1:0]       r_ptr, n_ptr;
    logic [hlt_pkg::SENT_W-1:0]      r_sent, n_sent;

    // latched input item
    logic [1:0]                      r_cmd;
    logic [3:0]                      r_idx;
    logic [hlt_pkg::ADDR_W-1:0]      r_peer;
    logic [hlt_pkg::TIME_W-1:0]      r_now;
    logic                            r_force;
    logic [hlt_pkg::LEN_W-1:0]       r_plen;

    // configuration
    logic [hlt_pkg::IVL_W-1:0]       r_interval;
    logic [hlt_pkg::RETRY_W-1:0]     r_max_retries;
    logic [hlt_pkg::LEN_W-1:0]       r_reply_len;

    // output register
    logic                            r_out_valid;
    logic [2:0]                      r_kind;
    logic [3:0]                      r_slot;
    logic [hlt_pkg::ADDR_W-1:0]      r_target;
    logic [hlt_pkg::TIME_W-1:0]      r_stamp;
    logic [4:0]                      r_probes;
    logic [hlt_pkg::MASK_W-1:0]      r_mask;
    logic                            r_last;

    // result being formed this cycle
    logic                            emit;
    logic [2:0]                      e_kind;
    logic [3:0]                      e_slot;
    logic [hlt_pkg::ADDR_W-1:0]      e_target;
    logic [hlt_pkg::TIME_W-1:0]      e_stamp;
    logic [4:0]                      e_probes;
    logic                            e_last;

    logic                            in_xfer;
    logic                            can_emit;
    logic                            at_end;
    hlt_pkg::t_entry                 rd_ent;
    hlt_pkg::t_tbl_wr                tbl_wr;
    hlt_pkg::t_slot_dec              dec;
    logic [hlt_pkg::SLOTS-1:0]       offline_nxt;
    hlt_pkg::t_pad_mask              mask_pad;

    hlt_table u_table (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rd_idx      (r_ptr),
        .o_rd          (rd_ent),
        .i_wr          (tbl_wr),
        .o_offline_nxt (offline_nxt)
    );

    hlt_due u_due (
        .i_ent         (rd_ent),
        .i_now         (r_now),
        .i_force       (r_force),
        .i_peer        (r_peer),
        .i_interval    (r_interval),
        .i_max_retries (r_max_retries),
        .o_dec         (dec)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // The output register can take a new result when empty or being drained.
    assign can_emit = !r_out_valid || !i_out_stall;
    assign at_end   = (r_ptr == hlt_pkg::PTR_W'(hlt_pkg::SLOTS - 1));

    // Offline flags after this cycle's table write, padded to the mask width.
    assign mask_pad = hlt_pkg::t_pad_mask'(offline_nxt);

    always_comb begin
        n_state  = r_state;
        n_ptr    = r_ptr;
        n_sent   = r_sent;
        emit     = 1'b0;
        e_kind   = hlt_pkg::KIND_ACK;
        e_slot   = '0;
        e_target = '0;
        e_stamp  = '0;
        e_probes = '0;
        e_last   = 1'b0;
        tbl_wr   = '0;
        tbl_wr.idx = r_ptr;

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_ptr  = '0;
                    n_sent = '0;
                    case (i_cmd)
                        hlt_pkg::CMD_LOAD:  n_state = S_LOAD;
                        hlt_pkg::CMD_TICK:  n_state = S_TICK;
                        hlt_pkg::CMD_REPLY: n_state = S_REPLY;
                        default:            n_state = S_IDLE;
                    endcase
                end
            end

            S_LOAD: begin
                if (can_emit) begin
                    // Out-of-range slots write nothing but are still acknowledged.
                    if (32'(r_idx) < hlt_pkg::SLOTS) begin
                        tbl_wr.we_addr  = 1'b1;
                        tbl_wr.we_time  = 1'b1;
                        tbl_wr.we_retry = 1'b1;
                        tbl_wr.we_off   = 1'b1;
                    end
                    tbl_wr.idx  = hlt_pkg::PTR_W'(r_idx);
                    tbl_wr.addr = r_peer;
                    emit    = 1'b1;
                    e_kind  = hlt_pkg::KIND_ACK;
                    e_slot  = r_idx;
                    e_last  = 1'b1;
                    n_state = S_IDLE;
                end
            end

            S_TICK: begin
                if (!dec.probe || can_emit) begin
                    if (dec.probe) begin
                        tbl_wr.we_time  = 1'b1;
                        tbl_wr.we_retry = 1'b1;
                        tbl_wr.ptime    = r_now;
                        tbl_wr.retry    = r_force ? '0 : rd_ent.retry + 1'b1;
                        emit     = 1'b1;
                        e_kind   = hlt_pkg::KIND_PROBE;
                        e_slot   = 4'(r_ptr);
                        e_target = rd_ent.addr;
                        e_stamp  = r_now;
                        n_sent   = r_sent + 1'b1;
                    end else if (dec.offline) begin
                        tbl_wr.we_off = 1'b1;
                        tbl_wr.off    = 1'b1;
                    end
                    if (at_end) begin
                        n_state = S_DONE;
                    end else begin
                        n_ptr = r_ptr + 1'b1;
                    end
                end
            end

            S_REPLY: begin
                if (r_plen != r_reply_len) begin
                    if (can_emit) begin
                        emit    = 1'b1;
                        e_kind  = hlt_pkg::KIND_ACK;
                        e_last  = 1'b1;
                        n_state = S_IDLE;
                    end
                end else if (dec.match) begin
                    // First used slot with this address wins.
                    if (can_emit) begin
                        tbl_wr.we_time  = 1'b1;
                        tbl_wr.we_retry = 1'b1;
                        tbl_wr.we_off   = 1'b1;
                        emit    = 1'b1;
                        e_kind  = hlt_pkg::KIND_MATCH;
                        e_slot  = 4'(r_ptr);
                        e_last  = 1'b1;
                        n_state = S_IDLE;
                    end
                end else if (at_end) begin
                    n_state = S_DONE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end

            S_DONE: begin
                if (can_emit) begin
                    emit   = 1'b1;
                    e_last = 1'b1;
                    if (r_cmd == hlt_pkg::CMD_TICK) begin
                        e_kind   = hlt_pkg::KIND_DONE;
                        e_probes = 5'(r_sent);
                    end else begin
                        e_kind   = hlt_pkg::KIND_UNKNOWN;
                    end
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_ptr         <= '0;
            r_sent        <= '0;
            r_out_valid   <= 1'b0;
            r_interval    <= hlt_pkg::RST_INTERVAL;
            r_max_retries <= hlt_pkg::RST_RETRIES;
            r_reply_len   <= hlt_pkg::RST_REPLY_LEN;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_sent  <= n_sent;

            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    hlt_pkg::CFG_INTERVAL:  r_interval    <= i_cfg_data;
                    hlt_pkg::CFG_RETRIES:   r_max_retries <= i_cfg_data[hlt_pkg::RETRY_W-1:0];
                    hlt_pkg::CFG_REPLY_LEN: r_reply_len   <= i_cfg_data[hlt_pkg::LEN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers: latched item and result, no reset needed.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cmd   <= i_cmd;
            r_idx   <= i_entry_index;
            r_peer  <= i_peer_address;
            r_now   <= i_now_ms;
            r_force <= i_force_req;
            r_plen  <= i_packet_length;
        end
        if (emit) begin
            r_kind   <= e_kind;
            r_slot   <= e_slot;
            r_target <= e_target;
            r_stamp  <= e_stamp;
            r_probes <= e_probes;
            r_mask   <= mask_pad[hlt_pkg::MASK_W-1:0];
            r_last   <= e_last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_kind;
    assign o_slot           = r_slot;
    assign o_target_address = r_target;
    assign o_probe_stamp    = r_stamp;
    assign o_probes_sent    = r_probes;
    assign o_offline_mask   = r_mask;
    assign o_last           = r_last;

endmodule

// ----- sim/heartbeat_liveness_table_checker.sv -----
// Transfer monitor, liveness-table predictor and result comparator.
// Depends on hlt_pkg; instantiated beside the block by heartbeat_liveness_table_test.
module heartbeat_liveness_table_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic [1:0]                   i_cmd,
    input  logic [3:0]                   i_entry_index,
    input  logic [hlt_pkg::ADDR_W-1:0]   i_peer_address,
    input  logic [hlt_pkg::TIME_W-1:0]   i_now_ms,
    input  logic                         i_force_req,
    input  logic [hlt_pkg::LEN_W-1:0]    i_packet_length,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic [2:0]                   i_kind,
    input  logic [3:0]                   i_slot,
    input  logic [hlt_pkg::ADDR_W-1:0]   i_target_address,
    input  logic [hlt_pkg::TIME_W-1:0]   i_probe_stamp,
    input  logic [4:0]                   i_probes_sent,
    input  logic [hlt_pkg::MASK_W-1:0]   i_offline_mask,
    input  logic                         i_last,
    input  logic                         i_cfg_valid,
    input  logic                         i_cfg_ready,
    input  logic [1:0]                   i_cfg_index,
    input  logic [hlt_pkg::IVL_W-1:0]    i_cfg_data,
    output int                           o_fail_count,
    output int                           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        hlt_pkg::t_kind                kind;
        logic [3:0]                    slot;
        logic [hlt_pkg::ADDR_W-1:0]    target;
        logic [hlt_pkg::TIME_W-1:0]    stamp;
        logic [4:0]                    sent;
        logic [hlt_pkg::MASK_W-1:0]    mask;
        logic                          last;
    } t_liveness_result;

    t_liveness_result   owed_results[$];

    logic [hlt_pkg::ADDR_W-1:0]  peer_addr  [hlt_pkg::SLOTS];
    logic [hlt_pkg::TIME_W-1:0]  probe_time [hlt_pkg::SLOTS];
    logic [hlt_pkg::RETRY_W-1:0] retries    [hlt_pkg::SLOTS];
    logic                        offline    [hlt_pkg::SLOTS];
    logic [hlt_pkg::IVL_W-1:0]   interval_ms;
    logic [hlt_pkg::RETRY_W-1:0] retry_limit;
    logic [hlt_pkg::LEN_W-1:0]   reply_len;
    int                          mismatches = 0;

    function automatic logic [hlt_pkg::MASK_W-1:0] offline_now();
        logic [hlt_pkg::MASK_W-1:0] m;
        m = '0;
        for (int i = 0; i < hlt_pkg::SLOTS && i < hlt_pkg::MASK_W; i++) m[i] = offline[i];
        return m;
    endfunction

    // Mask is taken at the moment the result is produced, mid-walk for probes.
    function automatic void owe(hlt_pkg::t_kind k, logic [3:0] s,
                                logic [hlt_pkg::ADDR_W-1:0] a,
                                logic [hlt_pkg::TIME_W-1:0] st, logic [4:0] n, logic fin);
        t_liveness_result r;
        r.kind   = k;
        r.slot   = s;
        r.target = a;
        r.stamp  = st;
        r.sent   = n;
        r.mask   = offline_now();
        r.last   = fin;
        owed_results.push_back(r);
    endfunction

    function automatic void step_table(logic [1:0] cmd, logic [3:0] idx,
                                       logic [hlt_pkg::ADDR_W-1:0] addr,
                                       logic [hlt_pkg::TIME_W-1:0] now,
                                       logic forced, logic [hlt_pkg::LEN_W-1:0] plen);
        int   probes;
        int   hit;
        logic send;
        probes = 0;
        hit    = -1;
        case (cmd)
            hlt_pkg::CMD_LOAD: begin
                if (int'(idx) < hlt_pkg::SLOTS) begin
                    peer_addr[idx]  = addr;
                    probe_time[idx] = '0;
                    retries[idx]    = '0;
                    offline[idx]    = 1'b0;
                end
                owe(hlt_pkg::KIND_ACK, idx, '0, '0, '0, 1'b1);
            end
            hlt_pkg::CMD_TICK: begin
                for (int i = 0; i < hlt_pkg::SLOTS; i++) begin
                    if (peer_addr[i] != '0) begin
                        send = forced;
                        if (forced) begin
                            retries[i] = '0;
                        end else if (probe_time[i] != '0 && now >= probe_time[i]
                                     && now - probe_time[i] >= interval_ms) begin
                            // at or above the limit: mark offline, send nothing
                            if (retries[i] >= retry_limit) begin
                                offline[i] = 1'b1;
                            end else begin
                                retries[i] = retries[i] + 1'b1;
                                send = 1'b1;
                            end
                        end
                        if (send) begin
                            probe_time[i] = now;
                            owe(hlt_pkg::KIND_PROBE, 4'(i), peer_addr[i], now, '0, 1'b0);
                            probes++;
                        end
                    end
                end
                owe(hlt_pkg::KIND_DONE, '0, '0, '0, 5'(probes), 1'b1);
            end
            hlt_pkg::CMD_REPLY: begin
                if (plen != reply_len) begin
                    owe(hlt_pkg::KIND_ACK, '0, '0, '0, '0, 1'b1);
                end else begin
                    // lowest used slot holding the address wins
                    for (int i = 0; i < hlt_pkg::SLOTS; i++)
                        if (hit < 0 && peer_addr[i] != '0 && peer_addr[i] == addr) hit = i;
                    if (hit >= 0) begin
                        probe_time[hit] = '0;
                        retries[hit]    = '0;
                        offline[hit]    = 1'b0;
                        owe(hlt_pkg::KIND_MATCH, 4'(hit), '0, '0, '0, 1'b1);
                    end else begin
                        owe(hlt_pkg::KIND_UNKNOWN, '0, '0, '0, '0, 1'b1);
                    end
                end
            end
            default: ;  // unused command: dropped without a result
        endcase
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("%0t MISMATCH %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_result();
        t_liveness_result want;
        if (owed_results.size() == 0) begin
            flag_mismatch($sformatf("unexpected result kind %0d slot %0d", i_kind, i_slot));
        end else begin
            want = owed_results.pop_front();
            if (i_kind !== want.kind || i_slot !== want.slot
                || i_target_address !== want.target || i_probe_stamp !== want.stamp
                || i_probes_sent !== want.sent || i_offline_mask !== want.mask
                || i_last !== want.last)
                flag_mismatch($sformatf({"got kind %0d slot %0d addr %h stamp %h sent %0d",
                    " mask %h last %b; want kind %0d slot %0d addr %h stamp %h sent %0d",
                    " mask %h last %b"},
                    i_kind, i_slot, i_target_address, i_probe_stamp, i_probes_sent,
                    i_offline_mask, i_last, want.kind, want.slot, want.target,
                    want.stamp, want.sent, want.mask, want.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < hlt_pkg::SLOTS; i++) begin
                peer_addr[i]  = '0;
                probe_time[i] = '0;
                retries[i]    = '0;
                offline[i]    = 1'b0;
            end
            interval_ms = hlt_pkg::RST_INTERVAL;
            retry_limit = hlt_pkg::RST_RETRIES;
            reply_len   = hlt_pkg::RST_REPLY_LEN;
            owed_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    hlt_pkg::CFG_INTERVAL:  interval_ms = i_cfg_data;
                    hlt_pkg::CFG_RETRIES:   retry_limit = i_cfg_data[hlt_pkg::RETRY_W-1:0];
                    hlt_pkg::CFG_REPLY_LEN: reply_len   = i_cfg_data[hlt_pkg::LEN_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) check_result();
            if (i_in_valid && !i_in_stall)
                step_table(i_cmd, i_entry_index, i_peer_address, i_now_ms,
                           i_force_req, i_packet_length);
        end
        o_fail_count <= mismatches;
        o_pending    <= owed_results.size();
    end

endmodule

// ----- sim/heartbeat_liveness_table_test.sv -----
// Top of the heartbeat liveness table testbench: clock, reset, stimulus, verdict.
// Depends on hlt_pkg, heartbeat_liveness_table and heartbeat_liveness_table_checker.
module heartbeat_liveness_table_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         RESET_CYCLES   = 8;
    localparam int         LONG_HOLD      = 300;
    localparam int         SETTLE_CYCLES  = hlt_pkg::SLOTS + 4;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam logic [1:0] CMD_UNUSED     = 2'd3;
    localparam logic [1:0] CFG_SPARE      = 2'd3;

    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         in_valid  = 1'b0;
    logic                         in_stall;
    logic [1:0]                   in_cmd    = hlt_pkg::CMD_LOAD;
    logic [3:0]                   in_index  = '0;
    logic [hlt_pkg::ADDR_W-1:0]   in_addr   = '0;
    logic [hlt_pkg::TIME_W-1:0]   in_now_ms = '0;
    logic                         in_forced = 1'b0;
    logic [hlt_pkg::LEN_W-1:0]    in_len    = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [2:0]                   res_kind;
    logic [3:0]                   res_slot;
    logic [hlt_pkg::ADDR_W-1:0]   res_target;
    logic [hlt_pkg::TIME_W-1:0]   res_stamp;
    logic [4:0]                   res_sent;
    logic [hlt_pkg::MASK_W-1:0]   res_mask;
    logic                         res_last;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [1:0]                   cfg_index = hlt_pkg::CFG_INTERVAL;
    logic [hlt_pkg::IVL_W-1:0]    cfg_data  = '0;
    int                           fail_count;
    int                           pending;

    // Stimulus-side copies of the register values, used to aim the random items.
    logic [hlt_pkg::IVL_W-1:0]    cur_interval = hlt_pkg::RST_INTERVAL;
    logic [hlt_pkg::LEN_W-1:0]    cur_len      = hlt_pkg::RST_REPLY_LEN;
    logic [hlt_pkg::TIME_W-1:0]   clock_ms     = 64'd1000;
    logic [hlt_pkg::ADDR_W-1:0]   peer_pool [6];

    // Flow control knobs: calm turns off all idling; want_hold asks for one long stall.
    logic                calm      = 1'b0;
    logic                want_hold = 1'b0;
    logic                hold_done = 1'b0;
    int                  quiet_cycles = 0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    heartbeat_liveness_table uut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_cmd            (in_cmd),
        .i_entry_index    (in_index),
        .i_peer_address   (in_addr),
        .i_now_ms         (in_now_ms),
        .i_force_req      (in_forced),
        .i_packet_length  (in_len),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_kind           (res_kind),
        .o_slot           (res_slot),
        .o_target_address (res_target),
        .o_probe_stamp    (res_stamp),
        .o_probes_sent    (res_sent),
        .o_offline_mask   (res_mask),
        .o_last           (res_last),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    heartbeat_liveness_table_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_cmd            (in_cmd),
        .i_entry_index    (in_index),
        .i_peer_address   (in_addr),
        .i_now_ms         (in_now_ms),
        .i_force_req      (in_forced),
        .i_packet_length  (in_len),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_kind           (res_kind),
        .i_slot           (res_slot),
        .i_target_address (res_target),
        .i_probe_stamp    (res_stamp),
        .i_probes_sent    (res_sent),
        .i_offline_mask   (res_mask),
        .i_last           (res_last),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // Result-side stall. Drive at the falling edge. Short bursts, now and then a
    // stretch with no stall at all, and one long hold-off when asked so the
    // block backs up and stalls its input.
    always begin
        @(negedge clk);
        if (want_hold && !hold_done) begin
            out_stall = 1'b1;
            repeat (LONG_HOLD) @(negedge clk);
            hold_done = 1'b1;
            out_stall = 1'b0;
        end else if (!calm && $urandom_range(0, 4) == 0) begin
            out_stall = 1'b1;
            repeat ($urandom_range(1, 7)) @(negedge clk);
            out_stall = 1'b0;
        end else if (!calm && $urandom_range(0, 15) == 0) begin
            out_stall = 1'b0;
            repeat ($urandom_range(20, 60)) @(negedge clk);
        end else begin
            out_stall = 1'b0;
        end
    end

    // Watchdog: end the run when no transfer of any kind happens for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("heartbeat_liveness_table test failed");
            $finish;
        end
    end

    // Present one item at the falling edge and hold it until the block takes it.
    // Valid stays high into the next item unless a random gap is drawn.
    task automatic send_item(input logic [1:0] cmd, input logic [3:0] idx,
                             input logic [hlt_pkg::ADDR_W-1:0] addr,
                             input logic [hlt_pkg::TIME_W-1:0] now,
                             input logic forced, input logic [hlt_pkg::LEN_W-1:0] plen);
        in_valid  = 1'b1;
        in_cmd    = cmd;
        in_index  = idx;
        in_addr   = addr;
        in_now_ms = now;
        in_forced = forced;
        in_len    = plen;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
    endtask

    // Drop valid, wait for every owed result, then idle for SETTLE_CYCLES.
    task automatic settle();
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [hlt_pkg::IVL_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
        case (idx)
            hlt_pkg::CFG_INTERVAL:  cur_interval = data;
            hlt_pkg::CFG_REPLY_LEN: cur_len      = data[hlt_pkg::LEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [hlt_pkg::IVL_W-1:0] ivl,
                              input logic [hlt_pkg::RETRY_W-1:0] lim,
                              input logic [hlt_pkg::LEN_W-1:0] len);
        settle();
        write_reg(hlt_pkg::CFG_INTERVAL, ivl);
        write_reg(hlt_pkg::CFG_RETRIES, hlt_pkg::IVL_W'(lim));
        write_reg(hlt_pkg::CFG_REPLY_LEN, hlt_pkg::IVL_W'(len));
    endtask

    // Mostly a known peer, sometimes the unused marker, sometimes a stranger.
    function automatic logic [hlt_pkg::ADDR_W-1:0] pick_address();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 75) return peer_pool[$urandom_range(0, 5)];
        if (roll < 88) return $urandom;
        return '0;
    endfunction

    // Well-formed traffic: loads from the pool, ticks that step time by about the
    // interval so peers come due and run out of retries, replies that mostly match.
    // Unused commands are thrown in as noise and do not count.
    task automatic random_phase(input int items);
        int                         count;
        int                         pick;
        int                         roll;
        int                         span;
        logic [hlt_pkg::TIME_W-1:0] stamp;
        count = 0;
        while (count < items) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                send_item(CMD_UNUSED, 4'($urandom), $urandom, {$urandom, $urandom},
                          1'($urandom), 6'($urandom));
            end else if (pick < 25) begin
                send_item(hlt_pkg::CMD_LOAD, 4'($urandom), pick_address(),
                          {$urandom, $urandom}, 1'($urandom), 6'($urandom));
                count++;
            end else if (pick < 65) begin
                roll = $urandom_range(0, 29);
                span = 2 * int'(cur_interval);
                if (roll == 0) begin
                    stamp = {$urandom, $urandom};
                end else if (roll < 4) begin
                    stamp = clock_ms - $urandom_range(1, 50);  // clock stepping back
                end else begin
                    clock_ms = clock_ms + $urandom_range(0, span);
                    stamp    = clock_ms;
                end
                send_item(hlt_pkg::CMD_TICK, 4'($urandom), $urandom, stamp,
                          $urandom_range(0, 5) == 0, 6'($urandom));
                count++;
            end else begin
                send_item(hlt_pkg::CMD_REPLY, 4'($urandom), pick_address(),
                          {$urandom, $urandom}, 1'($urandom),
                          ($urandom_range(0, 4) != 0) ? cur_len : 6'($urandom));
                count++;
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        peer_pool[0] = 32'hFFFF_FFFF;
        peer_pool[1] = 32'h0000_0001;
        for (int i = 2; i < 6; i++) peer_pool[i] = $urandom | 32'h1;

        // Directed part at reset settings: empty table, loads with a duplicate
        // address, never-probed peers, exact due boundary, clock running backwards.
        send_item(hlt_pkg::CMD_REPLY, 4'd0, 32'h0, '0, 1'b0, 6'd13);        // unused slot
        send_item(hlt_pkg::CMD_REPLY, 4'd0, 32'h1234_5678, '0, 1'b0, 6'd0); // wrong length
        send_item(hlt_pkg::CMD_LOAD, 4'd0, 32'hFFFF_FFFF, '0, 1'b0, 6'd0);
        send_item(hlt_pkg::CMD_LOAD, 4'd15, 32'h0000_0001, '0, 1'b0, 6'd0);
        send_item(hlt_pkg::CMD_LOAD, 4'd3, 32'hA5A5_C3C3, '0, 1'b0, 6'd0);
        send_item(hlt_pkg::CMD_LOAD, 4'd4, 32'hA5A5_C3C3, '0, 1'b0, 6'd0);  // duplicate
        send_item(hlt_pkg::CMD_LOAD, 4'd7, 32'h5A5A_3C3C, '0, 1'b0, 6'd0);
        send_item(hlt_pkg::CMD_LOAD, 4'd7, 32'h0, '0, 1'b0, 6'd0);          // back to unused
        send_item(hlt_pkg::CMD_TICK, 4'd0, 32'h0, 64'd1000, 1'b0, 6'd0);    // none probed yet
        send_item(hlt_pkg::CMD_TICK, 4'd0, 32'h0, 64'd0, 1'b1, 6'd0);       // forced at zero
        send_item(hlt_pkg::CMD_TICK, 4'd0, 32'h0, 64'd100000, 1'b0, 6'd0);  // never probed
        send_item(hlt_pkg::CMD_TICK, 4'd0, 32'h0, 64'd10000, 1'b1, 6'd0);
        send_item(hlt_pkg::CMD_TICK, 4'd0, 32'h0, 64'd14999, 1'b0, 6'd0);   // one short
        send_item(hlt_pkg::CMD_TICK, 4'd0, 32'h0, 64'd15000, 1'b0, 6'd0);   // exactly due
        send_item(hlt_pkg::CMD_TICK, 4'd0, 32'h0, 64'd3, 1'b0, 6'd0);       // time went back
        send_item(hlt_pkg::CMD_REPLY, 4'd0, 32'hA5A5_C3C3, '0, 1'b0, 6'd13); // lowest slot
        send_item(hlt_pkg::CMD_REPLY, 4'd0, 32'hFFFF_FFFF, '0, 1'b0, 6'd63); // bad length
        send_item(CMD_UNUSED, 4'hF, 32'hFFFF_FFFF, '1, 1'b1, 6'd63);
        send_item(hlt_pkg::CMD_TICK, 4'd0, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 6'd0);

        // Lowest settings: every due peer is at the retry limit straight away.
        set_config(16'd1, 3'd0, 6'd0);
        send_item(hlt_pkg::CMD_TICK, 4'd0, 32'h0, 64'd100, 1'b1, 6'd0);
        send_item(hlt_pkg::CMD_TICK, 4'd0, 32'h0, 64'd101, 1'b0, 6'd0);     // all go offline
        send_item(hlt_pkg::CMD_TICK, 4'd0, 32'h0, 64'd200, 1'b1, 6'd0);     // offline probed
        send_item(hlt_pkg::CMD_REPLY, 4'd0, 32'hFFFF_FFFF, '0, 1'b0, 6'd0); // clears offline
        send_item(hlt_pkg::CMD_LOAD, 4'd15, 32'h8000_0000, '0, 1'b0, 6'd0); // reload clears

        // Highest settings, plus a write to the spare index that must change nothing.
        set_config(16'hFFFF, 3'd7, 6'd63);
        write_reg(CFG_SPARE, hlt_pkg::IVL_W'($urandom));
        random_phase(35);

        // Fill the table, then hold the result side off while forced ticks pile up.
        set_config(16'($urandom_range(1, 300)), 3'($urandom_range(0, 3)),
                   6'($urandom_range(0, 63)));
        for (int i = 0; i < hlt_pkg::SLOTS; i++)
            send_item(hlt_pkg::CMD_LOAD, 4'(i), peer_pool[$urandom_range(0, 5)], '0,
                      1'b0, '0);
        want_hold = 1'b1;
        repeat (5) begin
            clock_ms = clock_ms + 1;
            send_item(hlt_pkg::CMD_TICK, 4'd0, 32'h0, clock_ms, 1'b1, 6'd0);
        end
        random_phase(20);

        set_config(16'($urandom_range(1, 40)), 3'($urandom), 6'($urandom));
        random_phase(35);

        // Last stretch with no idling on either side.
        set_config(16'($urandom_range(1, 1000)), 3'($urandom), 6'($urandom));
        calm = 1'b1;
        random_phase(35);

        settle();
        if (fail_count == 0)
            $display("heartbeat_liveness_table test passed");
        else
            $display("heartbeat_liveness_table test failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/hlt_pkg.sv
rtl/hlt_table.sv
rtl/hlt_due.sv
rtl/heartbeat_liveness_table.sv
sim/heartbeat_liveness_table_checker.sv
sim/heartbeat_liveness_table_test.sv
